>>> design/tdp_pkg.sv
// Shared types for the trial-division prime tester: states, number class, command and status.
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIVIDE,
    ST_CHECK,
    ST_FINISH
  } state_t;

  // Quick class of a loaded number before any division
  typedef enum logic [1:0] {
    CLS_COMPOSITE,
    CLS_PRIME,
    CLS_TEST
  } cls_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture the number, set divisor to three
    logic div_init;  // start a division of the number by the divisor
    logic step;      // one restoring-division bit
    logic next_div;  // advance divisor to the next odd value
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    cls_t cls;             // class of the captured number
    logic div_last;        // current step is the last bit of the division
    logic bound_exceeded;  // divisor is above the quotient
    logic rem_zero;        // remainder of the finished division is zero
  } status_t;

endpackage

`default_nettype wire

>>> design/tdp_datapath.sv
// Datapath of the prime tester: number and divisor registers and a bit-serial divider.
`timescale 1ns / 1ps
`default_nettype none

module tdp_datapath
  import tdp_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic [VALUE_WIDTH-1:0] number,
  input  wire cmd_t                   cmd,
  output status_t                     status
);

  localparam int CW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] n;
  logic [VALUE_WIDTH-1:0] d;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] quo;
  logic [CW-1:0]          cnt;

  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;
  cls_t                   cls;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem, quo[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, d};
  assign fits  = trial >= {1'b0, d};

  // Hold the number and step the divisor
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= number;
      d <= VALUE_WIDTH'(3);
    end else if (cmd.next_div) begin
      d <= d + VALUE_WIDTH'(2);
    end
  end

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= '0;
      quo <= n;
      cnt <= CW'(VALUE_WIDTH - 1);
    end else if (cmd.step) begin
      rem <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      quo <= {quo[VALUE_WIDTH-2:0], fits};
      cnt <= cnt - CW'(1);
    end
  end

  // Classify the number: below two, exactly two, even, or odd to test
  always_comb begin
    if (n < VALUE_WIDTH'(2)) begin
      cls = CLS_COMPOSITE;
    end else if (n == VALUE_WIDTH'(2)) begin
      cls = CLS_PRIME;
    end else if (!n[0]) begin
      cls = CLS_COMPOSITE;
    end else begin
      cls = CLS_TEST;
    end
  end

  assign status.cls            = cls;
  assign status.div_last       = (cnt == '0);
  assign status.bound_exceeded = (d > quo);
  assign status.rem_zero       = (rem == '0);

  // A load always restarts the divisor at three
  a_load_three: assert property (@(posedge clk) cmd.load |=> (d == VALUE_WIDTH'(3)))
    else $error("divisor not three after load");

  // Partial remainder stays below the divisor after every step
  a_rem_below: assert property (@(posedge clk) cmd.step && !cmd.load |=> (rem < d))
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

>>> design/tdp_ctrl.sv
// Controller of the prime tester: sequencing state machine and result output register.
`timescale 1ns / 1ps
`default_nettype none

module tdp_ctrl
  import tdp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  output logic         m_flag,
  output cmd_t         cmd,
  input  wire status_t status
);

  state_t state;
  state_t state_next;
  logic   flag;
  logic   flag_next;
  logic   load_out;

  assign s_tready = (state == ST_IDLE);

  // State and verdict registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    flag <= flag_next;
  end

  // Output register: hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load_out) begin
      m_flag <= flag;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    flag_next  = flag;
    cmd        = '0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        case (status.cls)
          CLS_PRIME: begin
            flag_next  = 1'b1;
            state_next = ST_FINISH;
          end
          CLS_TEST: begin
            cmd.div_init = 1'b1;
            state_next   = ST_DIVIDE;
          end
          default: begin
            flag_next  = 1'b0;
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.bound_exceeded) begin
          flag_next  = 1'b1;
          state_next = ST_FINISH;
        end else if (status.rem_zero) begin
          flag_next  = 1'b0;
          state_next = ST_FINISH;
        end else begin
          cmd.next_div = 1'b1;
          cmd.div_init = 1'b1;
          state_next   = ST_DIVIDE;
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // An accepted transfer is classified in the next cycle
  a_accept_classify: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_CLASSIFY)
    else $error("accepted number not classified");

  // Load, division start and division step never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.div_init, cmd.step}))
    else $error("overlapping datapath commands");

  // A free output slot in the finish state yields a valid result
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && (!m_tvalid || m_tready) |=> m_tvalid && state == ST_IDLE)
    else $error("finished verdict not presented");

endmodule

`default_nettype wire

>>> design/trial_division_prime_test.sv
// Top level of the trial-division prime tester: controller plus datapath.
//
// Usage: one unsigned number enters on the s_ channel; one verdict leaves on m_.
// s_tdata carries the number in its low VALUE_WIDTH bits; m_tdata bit 0 is 1 when
// the number is prime. s_tready is high only while no number is in work, so one
// number is tested at a time; a finished verdict sits in an output register, and
// the next number is taken while that verdict still waits for m_tready.
// Numbers below three and even numbers are settled without division; otherwise
// the odd divisors 3, 5, 7, ... are tried up to the integer square root or the
// first that divides. Each divisor runs the one-bit-per-cycle restoring divider
// over the number, then a check state compares the divisor with the quotient and
// tests the remainder.
// Reset (rst, synchronous) returns the controller to idle and drops m_tvalid.
// If the receiver stalls, the verdict holds on m_tdata and the controller waits
// with its next verdict until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test
  import tdp_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,   // number
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [7:0]                               m_tdata    // prime_flag, zero fill
);

  cmd_t    cmd;
  status_t status;
  logic    flag;

  tdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_flag   (flag),
    .cmd      (cmd),
    .status   (status)
  );

  tdp_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .number (s_tdata[VALUE_WIDTH-1:0]),
    .cmd    (cmd),
    .status (status)
  );

  // Pack the verdict into the low bit
  assign m_tdata = {7'b0, flag};

endmodule

`default_nettype wire

>>> tb/prime_verdict_checker.sv
`timescale 1ns / 1ps
// Checker for the prime tester: predicts each verdict from accepted numbers and compares it.
module prime_verdict_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // number
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // prime_flag, zero fill
  output int          mismatch_count,
  output int          verdicts_owed
);

  typedef struct {
    logic [31:0] number;
    bit          prime_flag;
  } verdict_t;

  verdict_t verdict_q[$];
  int       errors = 0;
  int       pending = 0;

  assign mismatch_count = errors;
  assign verdicts_owed  = pending;

  // Trial division by odd divisors up to the integer square root
  function automatic bit number_is_prime(input logic [31:0] n);
    logic [31:0] d;
    if (n < 32'd2) return 1'b0;
    if (n == 32'd2) return 1'b1;
    if (!n[0]) return 1'b0;
    for (d = 32'd3; d <= n / d; d += 32'd2) begin
      if (n % d == 32'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue a verdict per accepted number, compare each delivered verdict with the oldest
  always @(posedge clk) begin
    verdict_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want.number     = s_tdata;
        want.prime_flag = number_is_prime(s_tdata);
        verdict_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $error("prime_flag: no verdict expected, actual %0d", m_tdata[0]);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== want.prime_flag) begin
            $error("prime_flag for %0d: expected %0d, actual %0d",
                   want.number, want.prime_flag, m_tdata[0]);
            errors++;
          end
        end
      end
      pending = verdict_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the prime tester bench: clock, reset, number stimulus, receiver stalls and verdict.
module tb_top;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;    // number
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;    // prime_flag, zero fill
  int          fail_count;
  int          verdicts_owed;
  bit          tx_calm;
  bit          rx_calm;

  trial_division_prime_test #(
    .VALUE_WIDTH(32)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  prime_verdict_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (fail_count),
    .verdicts_owed  (verdicts_owed)
  );

  // Free-running 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold all inputs known, then release reset
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Offer one number after a random gap and hold it until the transfer
  task automatic offer_number(input logic [31:0] n);
    int gap;
    if ($urandom_range(0, 9) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= n;
    do @(posedge clk); while (!s_tready);
  endtask

  // Random number, mostly small so the divider loop stays short
  function automatic logic [31:0] random_number();
    logic [31:0] n;
    logic [31:0] f;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      n = $urandom_range(0, 65535);
    end else if (pick < 70) begin
      n = $urandom_range(0, 262143);
    end else if (pick < 85) begin
      n = $urandom() & 32'hFFFF_FFFE;
    end else begin
      // Large odd value with a factor of 3, 5 or 7: found within a few divisors
      f = 32'd3 + 32'd2 * $urandom_range(0, 2);
      n = ($urandom() % (32'hFFFF_FFFF / f - 32'd1)) * f;
      if (!n[0]) n += f;
    end
    return n;
  endfunction

  // Receiver: stall a random number of cycles before each verdict
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 19);
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [31:0] directed [$];
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25,
                 32'd49, 32'd97, 32'd121, 32'd63001, 32'd65521, 32'd65537,
                 32'd16752649, 32'd16777213, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAB};
    @(negedge clk);
    while (rst) @(negedge clk);

    // Edge values, squares of primes on the bound, and wide bit patterns
    foreach (directed[i]) offer_number(directed[i]);

    // Random numbers
    repeat (78) offer_number(random_number());

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (verdicts_owed == 0);
    repeat (100) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
